@@ sv/pair_continuity_scanner_defines.svh @@
// Assertion macros for the checker file of the continuity scanner.
`ifndef PAIR_CONTINUITY_SCANNER_DEFINES_SVH
`define PAIR_CONTINUITY_SCANNER_DEFINES_SVH

// The expression holds at every clock edge outside reset.
`define PCS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("pcs: property failed");

// The consequent holds in the same cycle as the antecedent.
`define PCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcs: implication failed");

// The consequent holds in the cycle after the antecedent.
`define PCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcs: next-cycle implication failed");

`endif

@@ sv/pcs_pkg.sv @@
`default_nettype none

package pcs_pkg;

    localparam int unsigned LINES_DEF = 7;
    localparam int unsigned IDX_W     = 3;
    localparam int unsigned POS_W     = 3;
    localparam int unsigned CNT_W     = 16;
    localparam int unsigned ADDR_W    = 4;
    localparam int unsigned DATA_W    = 32;

    localparam logic [1:0] REG_ORDER   = 2'd0;
    localparam logic [1:0] REG_DRIVE   = 2'd1;
    localparam logic [1:0] REG_RELEASE = 2'd2;

    typedef struct packed {
        logic             order_ok;
        logic [CNT_W-1:0] drive_settle;
        logic [CNT_W-1:0] release_settle;
    } t_ctl;

    // Scan order 0, 1, ..., lines-1 packed three bits per position.
    function automatic logic [8*IDX_W-1:0] ident_order(input int unsigned lines);
        logic [8*IDX_W-1:0] res;
        res = '0;
        for (int p = 0; p < 8; p++) begin
            if (p < int'(lines)) begin
                res[p*IDX_W +: IDX_W] = IDX_W'(p);
            end
        end
        return res;
    endfunction

    // First map bit of the pairs whose lower line index is a.
    function automatic logic [7:0] pair_base(input logic [IDX_W-1:0] a,
                                             input int unsigned lines);
        logic [7:0] prod;
        prod = 8'(a) * (8'(2 * lines - 1) - 8'(a));
        return prod >> 1;
    endfunction

endpackage

`default_nettype wire

@@ sv/pcs_regs.sv @@
`default_nettype none

module pcs_regs #(
    parameter int unsigned LINES = pcs_pkg::LINES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pcs_pkg::ADDR_W-1:0]  paddr,
    input  logic [pcs_pkg::DATA_W-1:0]  pwdata,
    output logic [pcs_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [pcs_pkg::IDX_W*LINES-1:0] o_order,
    output pcs_pkg::t_ctl               o_ctl
);
    import pcs_pkg::*;

    localparam int unsigned ORDER_W = IDX_W * LINES;
    localparam logic [8*IDX_W-1:0] ORDER_FULL = ident_order(LINES);
    localparam logic [ORDER_W-1:0] ORDER_RST  = ORDER_FULL[ORDER_W-1:0];

    logic [ORDER_W-1:0] r_order;
    logic [CNT_W-1:0]   r_drive;
    logic [CNT_W-1:0]   r_release;
    logic               wr_en;
    logic [1:0]         reg_sel;
    logic               order_ok;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order   <= ORDER_RST;
            r_drive   <= '0;
            r_release <= '0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_ORDER:   r_order   <= pwdata[ORDER_W-1:0];
                REG_DRIVE:   r_drive   <= pwdata[CNT_W-1:0];
                REG_RELEASE: r_release <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_ORDER:   prdata = DATA_W'(r_order);
            REG_DRIVE:   prdata = DATA_W'(r_drive);
            REG_RELEASE: prdata = DATA_W'(r_release);
            default:     prdata = '0;
        endcase
    end

    // The order is valid when every index is in range and none repeats.
    always_comb begin
        logic [IDX_W-1:0] ip;
        logic [IDX_W-1:0] iq;
        order_ok = 1'b1;
        for (int p = 0; p < int'(LINES); p++) begin
            ip = r_order[p*IDX_W +: IDX_W];
            if (32'(ip) >= LINES) begin
                order_ok = 1'b0;
            end
            for (int q = 0; q < p; q++) begin
                iq = r_order[q*IDX_W +: IDX_W];
                if (iq == ip) begin
                    order_ok = 1'b0;
                end
            end
        end
    end

    assign o_order             = r_order;
    assign o_ctl.order_ok      = order_ok;
    assign o_ctl.drive_settle  = r_drive;
    assign o_ctl.release_settle = r_release;

endmodule

`default_nettype wire

@@ sv/pcs_seq.sv @@
`default_nettype none

module pcs_seq #(
    parameter int unsigned LINES = pcs_pkg::LINES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic                             i_start_req,
    input  logic [LINES-1:0]                 i_sense_levels,
    input  logic [pcs_pkg::IDX_W*LINES-1:0]  i_order,
    input  pcs_pkg::t_ctl                    i_ctl,
    output logic [LINES-1:0]                 o_drive_low,
    output logic                             o_busy,
    output logic                             o_map_valid,
    output logic [LINES*(LINES-1)/2-1:0]     o_map,
    output logic                             o_refused
);
    import pcs_pkg::*;

    localparam int unsigned MAP_W = LINES * (LINES - 1) / 2;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_DRIVE   = 2'd1;
    localparam logic [1:0] PH_RELEASE = 2'd2;

    logic [1:0]       r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [MAP_W-1:0] r_acc, n_acc;
    logic [MAP_W-1:0] r_last, n_last;
    logic             valid;
    logic             refused;
    logic [MAP_W-1:0] sample_bits;
    logic [IDX_W-1:0] drv_idx;
    logic [IDX_W-1:0] out_idx;

    function automatic logic [IDX_W-1:0] line_at(input logic [POS_W-1:0] pos,
                                                 input logic [IDX_W*LINES-1:0] ord);
        logic [IDX_W-1:0] res;
        res = '0;
        for (int p = 0; p < int'(LINES); p++) begin
            if (pos == POS_W'(p)) begin
                res = ord[p*IDX_W +: IDX_W];
            end
        end
        return res;
    endfunction

    assign drv_idx = line_at(r_pos, i_order);

    // Pairs of the driven line with every later position that reads low.
    always_comb begin
        logic [IDX_W-1:0] sn;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [LINES-1:0] lv;
        logic [7:0]       bit_idx;
        sample_bits = '0;
        for (int p = 0; p < int'(LINES); p++) begin
            sn = i_order[p*IDX_W +: IDX_W];
            lv = i_sense_levels >> sn;
            lo = (drv_idx < sn) ? drv_idx : sn;
            hi = (drv_idx < sn) ? sn : drv_idx;
            bit_idx = pair_base(lo, LINES) + 8'(hi) - 8'(lo) - 8'd1;
            if (POS_W'(p) > r_pos && 32'(drv_idx) < LINES && 32'(sn) < LINES
                    && sn != drv_idx && !lv[0] && 32'(bit_idx) < MAP_W) begin
                sample_bits = sample_bits | (MAP_W'(1) << bit_idx);
            end
        end
    end

    always_comb begin
        logic             adv;
        logic [POS_W-1:0] pos_inc;
        n_phase = r_phase;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_last  = r_last;
        valid   = 1'b0;
        refused = 1'b0;
        adv     = 1'b0;
        pos_inc = r_pos + POS_W'(1);
        unique case (r_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    if (i_ctl.order_ok) begin
                        n_phase = PH_DRIVE;
                        n_pos   = '0;
                        n_cnt   = i_ctl.drive_settle;
                        n_acc   = '0;
                    end else begin
                        refused = 1'b1;
                    end
                end
            end
            PH_DRIVE: begin
                if (r_cnt != '0) begin
                    n_cnt = r_cnt - CNT_W'(1);
                end else begin
                    n_acc = r_acc | sample_bits;
                    if (i_ctl.release_settle == '0) begin
                        adv = 1'b1;
                    end else begin
                        n_phase = PH_RELEASE;
                        n_cnt   = i_ctl.release_settle;
                    end
                end
            end
            PH_RELEASE: begin
                if (r_cnt != '0) begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
                if (r_cnt <= CNT_W'(1)) begin
                    adv = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        if (adv) begin
            if (pos_inc >= POS_W'(LINES - 1)) begin
                n_last  = n_acc;
                n_phase = PH_IDLE;
                n_pos   = '0;
                n_cnt   = '0;
                valid   = 1'b1;
            end else begin
                n_phase = PH_DRIVE;
                n_pos   = pos_inc;
                n_cnt   = i_ctl.drive_settle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_acc   <= '0;
            r_last  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
            r_last  <= n_last;
        end
    end

    assign out_idx     = line_at(n_pos, i_order);
    assign o_drive_low = (n_phase == PH_DRIVE && 32'(out_idx) < LINES)
                         ? (LINES'(1) << out_idx) : '0;
    assign o_busy      = (n_phase != PH_IDLE);
    assign o_map_valid = valid;
    assign o_map       = n_last;
    assign o_refused   = refused;

endmodule

`default_nettype wire

@@ sv/pair_continuity_scanner.sv @@
// A result is registered as its item is accepted and is shown in the next cycle.
// Throughput: one item per cycle unless the output stalls; the sequencer state
// and result register update at the same edge and hold while output is stalled.
// Reset (synchronous, active low) returns the scan to idle, clears both maps,
// empties the result register and loads the identity scan order.
`default_nettype none

module pair_continuity_scanner #(
    parameter int unsigned LINES = pcs_pkg::LINES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pcs_pkg::ADDR_W-1:0]  paddr,
    input  logic [pcs_pkg::DATA_W-1:0]  pwdata,
    output logic [pcs_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_start_req,
    input  logic [LINES-1:0]            i_sense_levels,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [LINES-1:0]            o_drive_low,
    output logic                        o_busy_res,
    output logic                        o_map_valid,
    output logic [LINES*(LINES-1)/2-1:0] o_continuity_map,
    output logic                        o_order_invalid
);
    import pcs_pkg::*;

    localparam int unsigned MAP_W = LINES * (LINES - 1) / 2;

    logic [IDX_W*LINES-1:0] order;
    t_ctl                   ctl;
    logic                   accept;
    logic [LINES-1:0]       seq_drive;
    logic                   seq_busy;
    logic                   seq_valid;
    logic [MAP_W-1:0]       seq_map;
    logic                   seq_refused;

    logic                   r_out_valid;
    logic [LINES-1:0]       r_drive;
    logic                   r_busy;
    logic                   r_map_valid;
    logic [MAP_W-1:0]       r_map;
    logic                   r_refused;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    pcs_regs #(.LINES(LINES)) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_order (order),
        .o_ctl   (ctl)
    );

    pcs_seq #(.LINES(LINES)) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_start_req    (i_start_req),
        .i_sense_levels (i_sense_levels),
        .i_order        (order),
        .i_ctl          (ctl),
        .o_drive_low    (seq_drive),
        .o_busy         (seq_busy),
        .o_map_valid    (seq_valid),
        .o_map          (seq_map),
        .o_refused      (seq_refused)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_drive     <= seq_drive;
            r_busy      <= seq_busy;
            r_map_valid <= seq_valid;
            r_map       <= seq_map;
            r_refused   <= seq_refused;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_drive_low      = r_drive;
    assign o_busy_res       = r_busy;
    assign o_map_valid      = r_map_valid;
    assign o_continuity_map = r_map;
    assign o_order_invalid  = r_refused;

endmodule

`default_nettype wire

@@ sv/pcs_checker.sv @@
`default_nettype none
`include "pair_continuity_scanner_defines.svh"

module pcs_checker #(
    parameter int unsigned LINES = pcs_pkg::LINES_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [LINES-1:0]             o_drive_low,
    input logic                         o_busy_res,
    input logic                         o_map_valid,
    input logic [LINES*(LINES-1)/2-1:0] o_continuity_map,
    input logic                         o_order_invalid
);

    `PCS_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_continuity_map))
    `PCS_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_out_valid && o_map_valid, !o_busy_res && o_drive_low == '0)
    `PCS_ASSERT_IMP(a_refuse_idle, i_clk, i_rst_n, o_out_valid && o_order_invalid, !o_busy_res && !o_map_valid)
    `PCS_ASSERT_IMP(a_idle_no_drive, i_clk, i_rst_n, o_out_valid && !o_busy_res, o_drive_low == '0)
    `PCS_ASSERT_ALWAYS(a_drive_onehot, i_clk, i_rst_n, !o_out_valid || $onehot0(o_drive_low))

endmodule

bind pair_continuity_scanner pcs_checker #(.LINES(LINES)) u_pcs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_drive_low      (o_drive_low),
    .o_busy_res       (o_busy_res),
    .o_map_valid      (o_map_valid),
    .o_continuity_map (o_continuity_map),
    .o_order_invalid  (o_order_invalid)
);

`default_nettype wire

@@ test/pcs_continuity_checker.sv @@
module pcs_continuity_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pcs_pkg::ADDR_W-1:0] paddr,
    input  logic [pcs_pkg::DATA_W-1:0] pwdata,
    input  logic                       pready,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic                       i_start_req,
    input  logic [6:0]                 i_sense_levels,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [6:0]                 i_drive_low,
    input  logic                       i_busy_res,
    input  logic                       i_map_valid,
    input  logic [20:0]                i_continuity_map,
    input  logic                       i_order_invalid,
    output int                         o_fail_count,
    output int                         o_pending,
    output logic                       o_scan_idle
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NLINES = pcs_pkg::LINES_DEF;
    localparam int MAP_W  = NLINES * (NLINES - 1) / 2;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_DRIVE,
        SCAN_RELEASE
    } scan_phase_e;

    typedef struct packed {
        logic [NLINES-1:0] drive_low;
        logic              busy;
        logic              map_valid;
        logic [MAP_W-1:0]  cmap;
        logic              order_invalid;
    } scan_result_t;

    logic [3*NLINES-1:0] order_reg;
    logic [15:0]         drive_cfg;
    logic [15:0]         release_cfg;

    scan_phase_e         scan_phase;
    logic [2:0]          drive_pos;
    logic [15:0]         settle;
    logic [MAP_W-1:0]    acc_map;
    logic [MAP_W-1:0]    last_map;

    scan_result_t        pending_results[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_scan_idle  = 1'b1;
    end

    function automatic int line_at(input int p);
        return int'((order_reg >> (p * 3)) & 3'h7);
    endfunction

    function automatic bit order_valid();
        logic [7:0] seen;
        int         idx;
        seen = '0;
        for (int p = 0; p < NLINES; p++) begin
            idx = line_at(p);
            if (idx >= NLINES || seen[idx]) begin
                return 1'b0;
            end
            seen[idx] = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic int pair_bit(input int x, input int y);
        int a;
        int b;
        a = (x < y) ? x : y;
        b = (x < y) ? y : x;
        return a * (2 * NLINES - 1 - a) / 2 + (b - a - 1);
    endfunction

    function automatic void sample_lines(input logic [NLINES-1:0] levels);
        int drv;
        int sn;
        int bit_idx;
        drv = line_at(int'(drive_pos));
        for (int p = int'(drive_pos) + 1; p < NLINES; p++) begin
            sn = line_at(p);
            if (drv < NLINES && sn < NLINES && sn != drv && !levels[sn]) begin
                bit_idx = pair_bit(drv, sn);
                if (bit_idx < MAP_W) begin
                    acc_map[bit_idx] = 1'b1;
                end
            end
        end
    endfunction

    function automatic bit advance_position();
        drive_pos = drive_pos + 3'd1;
        if (int'(drive_pos) >= NLINES - 1) begin
            last_map   = acc_map;
            scan_phase = SCAN_IDLE;
            drive_pos  = '0;
            settle     = '0;
            return 1'b1;
        end
        scan_phase = SCAN_DRIVE;
        settle     = drive_cfg;
        return 1'b0;
    endfunction

    function automatic scan_result_t predict_tick(input logic start,
                                                  input logic [NLINES-1:0] levels);
        scan_result_t res;
        logic [7:0]   one_hot;
        res = '0;
        case (scan_phase)
            SCAN_IDLE: begin
                if (start) begin
                    if (order_valid()) begin
                        scan_phase = SCAN_DRIVE;
                        drive_pos  = '0;
                        settle     = drive_cfg;
                        acc_map    = '0;
                    end else begin
                        res.order_invalid = 1'b1;
                    end
                end
            end
            SCAN_DRIVE: begin
                if (settle != 0) begin
                    settle = settle - 16'd1;
                end else begin
                    sample_lines(levels);
                    if (release_cfg == 0) begin
                        res.map_valid = advance_position();
                    end else begin
                        scan_phase = SCAN_RELEASE;
                        settle     = release_cfg;
                    end
                end
            end
            default: begin
                if (settle != 0) begin
                    settle = settle - 16'd1;
                end
                if (settle == 0) begin
                    res.map_valid = advance_position();
                end
            end
        endcase
        if (scan_phase == SCAN_DRIVE) begin
            one_hot = 8'd1 << line_at(int'(drive_pos));
            res.drive_low = one_hot[NLINES-1:0];
        end
        res.busy = (scan_phase != SCAN_IDLE);
        res.cmap = last_map;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        scan_result_t want;
        if (!i_rst_n) begin
            order_reg   = {3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
            drive_cfg   = '0;
            release_cfg = '0;
            scan_phase  = SCAN_IDLE;
            drive_pos   = '0;
            settle      = '0;
            acc_map     = '0;
            last_map    = '0;
            pending_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no item waiting", 32'(i_continuity_map), 0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_drive_low !== want.drive_low)
                        report_mismatch("drive_low", 32'(i_drive_low), 32'(want.drive_low));
                    if (i_busy_res !== want.busy)
                        report_mismatch("busy_res", 32'(i_busy_res), 32'(want.busy));
                    if (i_map_valid !== want.map_valid)
                        report_mismatch("map_valid", 32'(i_map_valid), 32'(want.map_valid));
                    if (i_continuity_map !== want.cmap)
                        report_mismatch("continuity_map", 32'(i_continuity_map),
                                        32'(want.cmap));
                    if (i_order_invalid !== want.order_invalid)
                        report_mismatch("order_invalid", 32'(i_order_invalid),
                                        32'(want.order_invalid));
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_results.push_back(predict_tick(i_start_req, i_sense_levels));
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[pcs_pkg::ADDR_W-1:2])
                    pcs_pkg::REG_ORDER:   order_reg   = pwdata[3*NLINES-1:0];
                    pcs_pkg::REG_DRIVE:   drive_cfg   = pwdata[15:0];
                    pcs_pkg::REG_RELEASE: release_cfg = pwdata[15:0];
                    default: ;
                endcase
            end
        end
        o_pending   = pending_results.size();
        o_scan_idle = (scan_phase == SCAN_IDLE);
    end

endmodule

@@ test/pair_continuity_scanner_tb.sv @@
module pair_continuity_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NLINES = pcs_pkg::LINES_DEF;
    localparam int MAP_W  = NLINES * (NLINES - 1) / 2;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [pcs_pkg::ADDR_W-1:0] paddr = '0;
    logic [pcs_pkg::DATA_W-1:0] pwdata = '0;
    logic [pcs_pkg::DATA_W-1:0] prdata;
    logic                       pready;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic                       i_start_req = 1'b0;
    logic [NLINES-1:0]          i_sense_levels = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [NLINES-1:0]          o_drive_low;
    logic                       o_busy_res;
    logic                       o_map_valid;
    logic [MAP_W-1:0]           o_continuity_map;
    logic                       o_order_invalid;

    int   fail_count;
    int   pending;
    logic scan_idle;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   items_sent = 0;
    int   setups = 0;

    pair_continuity_scanner u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_start_req      (i_start_req),
        .i_sense_levels   (i_sense_levels),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_drive_low      (o_drive_low),
        .o_busy_res       (o_busy_res),
        .o_map_valid      (o_map_valid),
        .o_continuity_map (o_continuity_map),
        .o_order_invalid  (o_order_invalid)
    );

    pcs_continuity_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_start_req      (i_start_req),
        .i_sense_levels   (i_sense_levels),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_drive_low      (o_drive_low),
        .i_busy_res       (o_busy_res),
        .i_map_valid      (o_map_valid),
        .i_continuity_map (o_continuity_map),
        .i_order_invalid  (o_order_invalid),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_scan_idle      (scan_idle)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= stall_pct);
    end

    initial begin
        #50_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [NLINES-1:0] rand_levels();
        logic [NLINES-1:0] v;
        v = NLINES'($urandom);
        if ($urandom_range(1) == 1) begin
            v = v | NLINES'($urandom);
        end
        return v;
    endfunction

    function automatic logic [3*NLINES-1:0] random_perm();
        int                  line_idx[NLINES];
        int                  j;
        int                  tmp;
        logic [3*NLINES-1:0] packed_order;
        for (int i = 0; i < NLINES; i++) begin
            line_idx[i] = i;
        end
        for (int i = NLINES - 1; i > 0; i--) begin
            j = $urandom_range(i, 0);
            tmp = line_idx[i];
            line_idx[i] = line_idx[j];
            line_idx[j] = tmp;
        end
        packed_order = '0;
        for (int i = 0; i < NLINES; i++) begin
            packed_order[3*i +: 3] = 3'(line_idx[i]);
        end
        return packed_order;
    endfunction

    function automatic logic [3*NLINES-1:0] broken_order();
        logic [3*NLINES-1:0] ord;
        int                  p;
        int                  q;
        ord = random_perm();
        p = $urandom_range(NLINES - 1);
        if ($urandom_range(1) == 1) begin
            ord[3*p +: 3] = 3'd7;
        end else begin
            q = (p + 1 + $urandom_range(NLINES - 2)) % NLINES;
            ord[3*p +: 3] = ord[3*q +: 3];
        end
        return ord;
    endfunction

    task automatic send_item(input logic start, input logic [NLINES-1:0] levels);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_start_req    = start;
        i_sense_levels = levels;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic finish_scan();
        while (!scan_idle) begin
            send_item(1'($urandom_range(1)), rand_levels());
        end
    endtask

    task automatic drain();
        finish_scan();
        i_in_valid = 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_idx, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(input logic [3*NLINES-1:0] ord, input logic [15:0] drv,
                              input logic [15:0] rel);
        drain();
        apb_write(pcs_pkg::REG_ORDER, 32'(ord));
        apb_write(pcs_pkg::REG_DRIVE, 32'(drv));
        apb_write(pcs_pkg::REG_RELEASE, 32'(rel));
        setups++;
    endtask

    initial begin
        int idle_mix[4];
        int stall_mix[4];
        idle_mix  = '{0, 57, 0, 24};
        stall_mix = '{0, 0, 57, 24};

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset settings: identity order, no settle delays.
        send_item(1'b0, 7'h7F);
        send_item(1'b1, 7'h7F);
        send_item(1'b0, 7'h00);
        send_item(1'b1, 7'h00);
        send_item(1'b0, 7'h00);
        send_item(1'b0, 7'h00);
        send_item(1'b0, 7'h00);
        send_item(1'b1, 7'h00);
        send_item(1'b1, 7'h2A);
        send_item(1'b0, 7'h55);
        send_item(1'b0, 7'h2A);
        send_item(1'b0, 7'h7F);
        send_item(1'b0, 7'h3C);
        send_item(1'b0, 7'h41);
        send_item(1'b0, 7'h1E);

        // Orders that are not permutations must be refused.
        set_config('0, 16'd0, 16'd0);
        send_item(1'b1, 7'h00);
        set_config({3*NLINES{1'b1}}, 16'd0, 16'd0);
        send_item(1'b1, 7'h7F);
        set_config(broken_order(), 16'd0, 16'd0);
        send_item(1'b1, 7'h00);

        set_config({3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6}, 16'd1, 16'd2);
        send_item(1'b1, 7'h00);
        finish_scan();

        set_config(random_perm(), 16'd12, 16'd7);
        send_item(1'b1, rand_levels());
        finish_scan();

        for (int ph = 0; ph < 4; ph++) begin
            for (int k = 0; k < 5; k++) begin
                if (k == 0) begin
                    set_config(random_perm(), 16'd0, 16'd0);
                end else if ($urandom_range(4) == 0) begin
                    set_config(broken_order(), 16'($urandom_range(3)),
                               16'($urandom_range(3)));
                end else begin
                    set_config(random_perm(), 16'($urandom_range(3)),
                               16'($urandom_range(3)));
                end
                idle_pct  = idle_mix[ph];
                stall_pct = stall_mix[ph];
                repeat (45) begin
                    send_item(1'($urandom_range(9) == 0), rand_levels());
                end
            end
        end

        drain();
        repeat (5) @(negedge i_clk);

        $display("Sent %0d items under four sender/receiver idle mixes and %0d register setups,",
                 items_sent, setups);
        $display("covering refused orders, ignored starts and longer settle delays.");
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ pair_continuity_scanner.f @@
+incdir+sv
sv/pcs_pkg.sv
sv/pcs_regs.sv
sv/pcs_seq.sv
sv/pair_continuity_scanner.sv
sv/pcs_checker.sv
test/pcs_continuity_checker.sv
test/pair_continuity_scanner_tb.sv
